// ===== hdl/slab_page_buffer_allocator_defines.svh =====
// Assertion macros shared by the slab page buffer allocator RTL.
`ifndef SLAB_PAGE_BUFFER_ALLOCATOR_DEFINES_SVH
`define SLAB_PAGE_BUFFER_ALLOCATOR_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SPBA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SPBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spba_pkg.sv =====
// Types and constants of the slab page buffer allocator.
`timescale 1ns / 1ps
package spba_pkg;

  localparam int AddrW = 64;
  localparam int SizeW = 12;
  localparam int OpW = 2;
  localparam int StatusW = 3;
  localparam int UsedW = 10;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 64;

  localparam int SizeMinInt = 8;
  localparam int SizeMaxInt = 2048;
  localparam logic [SizeW-1:0] SizeMin = SizeW'(SizeMinInt);
  localparam logic [SizeW-1:0] SizeMax = SizeW'(SizeMaxInt);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [UsedW-1:0] used_t;
  typedef logic [SizeW-1:0] size_t;

  // Operation codes.
  localparam logic [OpW-1:0] OpSetup = 2'd0;
  localparam logic [OpW-1:0] OpAlloc = 2'd1;
  localparam logic [OpW-1:0] OpFree  = 2'd2;
  localparam logic [OpW-1:0] OpNop   = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] StAllocated = 3'd0;
  localparam logic [StatusW-1:0] StEmpty     = 3'd1;
  localparam logic [StatusW-1:0] StFreed     = 3'd2;
  localparam logic [StatusW-1:0] StIgnored   = 3'd3;
  localparam logic [StatusW-1:0] StSetup     = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBaseAddress = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBufferSize  = 1'd1;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]   alloc_address;
    logic [StatusW-1:0] status;
    logic [UsedW-1:0]   used_count;
  } out_item_t;

endpackage

// ===== hdl/spba_ram.sv =====
// Single-port-write, single-port-read synchronous RAM holding the free-offset queue.
`timescale 1ns / 1ps
module spba_ram #(
  parameter int Depth = 512,
  parameter int Width = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/slab_page_buffer_allocator.sv =====
// Top level of the slab page buffer allocator: control, queue pointers and result register.
//
//   Channel   Direction  Handshake                 Payload
//   in        in         in_valid_i / in_stall_o   spba_pkg::in_item_t  (op, address)
//   out       out        out_valid_o / out_stall_i spba_pkg::out_item_t (alloc_address,
//                                                  status, used_count)
//   cfg       in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Allocate, free and no-op items go from S_IDLE, where they are accepted, to S_DONE,
// which collects the queue RAM read data and loads the result register.
// Setup runs the S_FILL sweep: the queue RAM write port lays down one buffer offset
// per cycle, and the sweep itself finds the count, min(PAGE_BYTES / size, MAX_BUFFERS).
// Reset is asynchronous and active low; the queue RAM has no clearing pass and is
// never read at an entry that a setup or free has not written.
// A stalled output holds its result while the next item is already accepted.
`timescale 1ns / 1ps
`include "slab_page_buffer_allocator_defines.svh"
module slab_page_buffer_allocator #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_BUFFERS = 512
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  spba_pkg::in_item_t                      in_item_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output spba_pkg::out_item_t                     out_item_o,
  input  logic                                    cfg_we_i,
  input  logic [spba_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [spba_pkg::CfgDataW-1:0]           cfg_wdata_i
);

  // Offsets lie inside the page; counts reach MAX_BUFFERS itself.
  localparam int OffW = $clog2(PAGE_BYTES);
  localparam int IdxW = $clog2(MAX_BUFFERS);
  localparam int CntW = $clog2(MAX_BUFFERS + 1);
  localparam int TailW = CntW + 1;
  localparam int SumW = $clog2(PAGE_BYTES + spba_pkg::SizeMaxInt + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  spba_pkg::addr_t base_q;
  spba_pkg::size_t size_q;

  // Queue bookkeeping.
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] in_use_q, in_use_d;

  // Setup sweep.
  spba_pkg::size_t fill_size_q, fill_size_d;
  logic [SumW-1:0] fill_off_q, fill_off_d;
  logic [CntW-1:0] fill_cnt_q, fill_cnt_d;
  logic [SumW-1:0] fill_sum;
  logic            fill_more;

  // Pending result of the current item.
  logic [spba_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic                         res_alloc_q, res_alloc_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  spba_pkg::out_item_t out_q, out_d;
  logic                out_free;
  logic                out_load;

  // Queue RAM port signals.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [OffW-1:0] mem_wdata;
  logic            mem_re;
  logic [OffW-1:0] mem_rdata;

  logic            in_accept;
  spba_pkg::addr_t free_diff;
  logic            free_ok;
  spba_pkg::size_t size_clamped;
  logic [TailW-1:0] tail_sum;
  logic [TailW-1:0] tail_adj;
  logic [IdxW-1:0]  head_next;
  logic [CntW:0]    occupancy;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Configuration writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= spba_pkg::SizeMin;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spba_pkg::CfgBaseAddress: base_q <= cfg_wdata_i;
        spba_pkg::CfgBufferSize:  size_q <= cfg_wdata_i[spba_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // The configured size is clamped into the supported buffer range at setup.
  assign size_clamped = (size_q < spba_pkg::SizeMin) ? spba_pkg::SizeMin :
                        (size_q > spba_pkg::SizeMax) ? spba_pkg::SizeMax : size_q;

  // A free is taken when the address falls inside the page, something is in
  // use, and the queue still has room.
  assign free_diff = in_item_i.address - base_q;
  assign free_ok   = (free_diff < spba_pkg::addr_t'(PAGE_BYTES)) &&
                     (in_use_q != '0) &&
                     (count_q < CntW'(MAX_BUFFERS));

  // Tail slot is head plus count, wrapped once around the queue depth.
  assign tail_sum  = TailW'(head_q) + TailW'(count_q);
  assign tail_adj  = (tail_sum >= TailW'(MAX_BUFFERS)) ?
                     TailW'(tail_sum - TailW'(MAX_BUFFERS)) : tail_sum;
  assign head_next = (head_q == IdxW'(MAX_BUFFERS - 1)) ? '0 : IdxW'(head_q + 1'b1);

  // The sweep keeps going while the next buffer ends inside the page and fewer than MAX_BUFFERS are laid.
  assign fill_sum  = fill_off_q + SumW'(fill_size_q);
  assign fill_more = (fill_sum <= SumW'(PAGE_BYTES)) && (fill_cnt_q < CntW'(MAX_BUFFERS));

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    in_use_d     = in_use_q;
    fill_size_d  = fill_size_q;
    fill_off_d   = fill_off_q;
    fill_cnt_d   = fill_cnt_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_alloc_d = 1'b0;
          state_d     = S_DONE;
          case (in_item_i.op)
            spba_pkg::OpSetup: begin
              fill_size_d = size_clamped;
              fill_off_d  = '0;
              fill_cnt_d  = '0;
              head_d      = '0;
              count_d     = '0;
              in_use_d    = '0;
              state_d     = S_FILL;
            end
            spba_pkg::OpAlloc: begin
              if (count_q == '0) begin
                res_status_d = spba_pkg::StEmpty;
              end else begin
                mem_re       = 1'b1;
                head_d       = head_next;
                count_d      = count_q - 1'b1;
                in_use_d     = in_use_q + 1'b1;
                res_status_d = spba_pkg::StAllocated;
                res_alloc_d  = 1'b1;
              end
            end
            spba_pkg::OpFree: begin
              if (free_ok) begin
                mem_we       = 1'b1;
                mem_waddr    = tail_adj[IdxW-1:0];
                mem_wdata    = free_diff[OffW-1:0];
                count_d      = count_q + 1'b1;
                in_use_d     = in_use_q - 1'b1;
                res_status_d = spba_pkg::StFreed;
              end else begin
                res_status_d = spba_pkg::StIgnored;
              end
            end
            default: begin
              res_status_d = spba_pkg::StIgnored;
            end
          endcase
        end
      end
      S_FILL: begin
        if (fill_more) begin
          mem_we     = 1'b1;
          mem_waddr  = fill_cnt_q[IdxW-1:0];
          mem_wdata  = fill_off_q[OffW-1:0];
          fill_cnt_d = fill_cnt_q + 1'b1;
          fill_off_d = fill_sum;
        end else begin
          count_d      = fill_cnt_q;
          res_status_d = spba_pkg::StSetup;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The allocated address uses the base at delivery time and the RAM read data.
  always_comb begin
    out_d.alloc_address = res_alloc_q ? (base_q + spba_pkg::addr_t'(mem_rdata)) : '0;
    out_d.status        = res_status_q;
    out_d.used_count    = spba_pkg::used_t'(in_use_q);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_size_q  <= fill_size_d;
    fill_off_q   <= fill_off_d;
    fill_cnt_q   <= fill_cnt_d;
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  spba_ram #(
    .Depth(MAX_BUFFERS),
    .Width(OffW)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(head_q),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign occupancy = (CntW + 1)'(count_q) + (CntW + 1)'(in_use_q);

  `SPBA_ASSERT_IMPL(a_queue_capacity, 1'b1, occupancy <= (CntW + 1)'(MAX_BUFFERS), "queued plus in-use buffers exceed capacity")
  `SPBA_ASSERT_IMPL(a_accept_when_idle, in_accept, state_q == S_IDLE, "item accepted while busy")
  `SPBA_ASSERT_NEXT(a_done_loads_output, state_q == S_DONE && out_free, out_valid_q && state_q == S_IDLE, "finished result not loaded")
  `SPBA_ASSERT_NEXT(a_fill_ends_in_done, state_q == S_FILL && !fill_more, state_q == S_DONE && count_q == $past(fill_cnt_q), "setup sweep did not publish its count")

endmodule

// ===== verif/spba_checker.sv =====
// Checker for the slab page buffer allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module spba_checker
  import spba_pkg::*;
#(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_BUFFERS = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  output int unsigned           errors_o,
  output int unsigned           outstanding_o
);

  localparam int IdxW = $clog2(MAX_BUFFERS);

  // Shadow copy of the allocator: free offset ring, pointers and registers.
  logic [SizeW-1:0] offset_ring [MAX_BUFFERS];
  logic [IdxW-1:0]  ring_head;
  logic [UsedW-1:0] ring_count;
  logic [UsedW-1:0] in_use;
  logic [UsedW-1:0] buf_total;
  addr_t            page_base;
  size_t            buf_size;

  out_item_t   expected_results [$];
  out_item_t   want;
  int unsigned mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 200) $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one item to the shadow state and returns the result it causes.
  function automatic out_item_t allocator_step(input in_item_t item);
    out_item_t       res;
    size_t           sz;
    int unsigned     n;
    addr_t           off;
    logic [IdxW-1:0] tail;
    res = '0;
    res.status = StIgnored;
    case (item.op)
      OpSetup: begin
        sz = buf_size;
        if (sz < SizeMin) sz = SizeMin;
        if (sz > SizeMax) sz = SizeMax;
        n = PAGE_BYTES / sz;
        if (n > MAX_BUFFERS) n = MAX_BUFFERS;
        for (int unsigned i = 0; i < n; i++) offset_ring[i] = SizeW'(i * sz);
        ring_head  = '0;
        ring_count = UsedW'(n);
        buf_total  = UsedW'(n);
        in_use     = '0;
        res.status = StSetup;
      end
      OpAlloc: begin
        if (ring_count == 0) begin
          res.status = StEmpty;
        end else begin
          res.alloc_address = page_base + addr_t'(offset_ring[ring_head]);
          res.status        = StAllocated;
          ring_head         = ring_head + 1'b1;
          ring_count        = ring_count - 1'b1;
          in_use            = in_use + 1'b1;
        end
      end
      OpFree: begin
        off = item.address - page_base;
        if (off < PAGE_BYTES && in_use != 0 && ring_count < MAX_BUFFERS) begin
          tail              = ring_head + IdxW'(ring_count);
          offset_ring[tail] = off[SizeW-1:0];
          ring_count        = ring_count + 1'b1;
          in_use            = in_use - 1'b1;
          res.status        = StFreed;
        end
      end
      default: ;
    endcase
    res.used_count = in_use;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head  = '0;
      ring_count = '0;
      in_use     = '0;
      buf_total  = '0;
      page_base  = '0;
      buf_size   = SizeMin;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgBaseAddress: page_base = cfg_wdata_i;
          CfgBufferSize:  buf_size  = cfg_wdata_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no expected result");
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.alloc_address !== want.alloc_address)
            report_mismatch($sformatf("alloc_address %h, expected %h",
                                      out_item_i.alloc_address, want.alloc_address));
          if (out_item_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item_i.status, want.status));
          if (out_item_i.used_count !== want.used_count)
            report_mismatch($sformatf("used_count %0d, expected %0d",
                                      out_item_i.used_count, want.used_count));
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(allocator_step(in_item_i));
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the slab page buffer allocator: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
  import spba_pkg::*;

  localparam int          PageBytes   = 4096;
  localparam int          MaxBuffers  = 512;
  localparam int unsigned RandomItems = 1550;
  // Generous bound: far above the slowest legal run with every stall at its longest.
  localparam int unsigned CycleLimit  = 1000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Idle-free stretches: while calm is set neither side inserts gaps or stalls.
  logic        calm = 1'b0;
  int unsigned calm_left = 0;
  int unsigned stall_left = 0;

  // What the stimulus knows about the current page, used to aim free requests.
  addr_t       cur_base = '0;
  int unsigned cur_size = 8;
  int unsigned cur_count = 512;
  int unsigned random_sent = 0;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  slab_page_buffer_allocator #(
    .PAGE_BYTES (PageBytes),
    .MAX_BUFFERS(MaxBuffers)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  spba_checker #(
    .PAGE_BYTES (PageBytes),
    .MAX_BUFFERS(MaxBuffers)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .errors_o     (mismatches),
    .outstanding_o(outstanding)
  );

  // Gap lengths: mostly short, some medium and a few long ones.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Toggle between calm stretches and stretches with random idling.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(3) == 0);
      calm_left = $urandom_range(400, 100);
    end else begin
      calm_left--;
    end
  end

  // The result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(99) < 30) stall_left = random_gap();
    end
  end

  // Offers one item and holds it until the transfer happens. The valid is lowered
  // only when a gap follows, so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [OpW-1:0] item_op, input addr_t item_address);
    int unsigned gap;
    gap = (calm || $urandom_range(1) == 0) ? 0 : random_gap();
    in_valid <= 1'b1;
    in_item  <= '{op: item_op, address: item_address};
    do @(posedge clk); while (in_stall);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items and waits until every expected result has been taken.
  // The checker publishes its count through a register, hence the edge before each test.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the trailing edge keeps write enables of two calls apart.
  // Only called after drain, so the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CfgBaseAddress) begin
      cur_base = data;
    end else begin
      cur_size = data[SizeW-1:0];
      if (cur_size < SizeMinInt) cur_size = SizeMinInt;
      if (cur_size > SizeMaxInt) cur_size = SizeMaxInt;
      cur_count = PageBytes / cur_size;
      if (cur_count > MaxBuffers) cur_count = MaxBuffers;
    end
  endtask

  // Most free requests name a real buffer of the page; the rest probe the edges
  // of the page, unaligned offsets and arbitrary addresses.
  function automatic addr_t pick_free_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return cur_base + addr_t'($urandom_range(cur_count - 1) * cur_size);
    if (r < 72) return cur_base + addr_t'($urandom_range(PageBytes - 1));
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return cur_base - 1;
        1:       return cur_base + PageBytes;
        2:       return cur_base + PageBytes - 1;
        default: return cur_base;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Mostly mid-sized buffers, so that the pool runs dry now and then.
  function automatic size_t pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return size_t'($urandom_range(512, 64));
    if (r < 60) return size_t'($urandom_range(SizeMaxInt, SizeMinInt));
    if (r < 70) return ($urandom_range(1) == 0) ? SizeMax : size_t'($urandom_range(4095, 2049));
    if (r < 80) return size_t'($urandom_range(SizeMinInt));
    return size_t'($urandom_range(1024, 128));
  endfunction

  function automatic addr_t pick_base();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return {$urandom, $urandom};
    if (r < 50) return 64'hFFFF_FFFF_FFFF_F000 | addr_t'($urandom_range(4095));
    if (r < 70) return addr_t'($urandom_range(4095));
    return {$urandom, $urandom} & ~64'hFFF;
  endfunction

  initial begin
    int unsigned    phase_len;
    int unsigned    alloc_bias;
    int unsigned    r;
    logic [OpW-1:0] op;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part. Before any setup an allocate finds nothing and a free finds
    // nothing in use; the no-op code answers as an ignored free.
    send_item(OpAlloc, '0);
    send_item(OpFree, '0);
    send_item(OpNop, '1);
    drain();

    // A page near the top of the address space with the largest buffer: the
    // second buffer's address wraps around zero.
    write_reg(CfgBaseAddress, 64'hFFFF_FFFF_FFFF_FC00);
    write_reg(CfgBufferSize, SizeMax);
    send_item(OpSetup, '0);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    send_item(OpFree, cur_base - 1);
    send_item(OpFree, cur_base + PageBytes);
    // An unaligned offset inside the page, freed twice, comes back twice as given.
    send_item(OpFree, cur_base + PageBytes - 1);
    send_item(OpFree, cur_base + PageBytes - 1);
    send_item(OpFree, cur_base);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    drain();

    // Moving the base after setup: frees and allocations follow the new base.
    write_reg(CfgBaseAddress, '0);
    send_item(OpFree, 64'h10);
    send_item(OpAlloc, '0);
    send_item(OpFree, '1);
    drain();

    // Sizes below the minimum act as the minimum, which caps the count of buffers.
    write_reg(CfgBufferSize, size_t'(7));
    send_item(OpSetup, '0);
    send_item(OpFree, '0);
    send_item(OpAlloc, '0);
    drain();

    // Sizes above the maximum act as the maximum.
    write_reg(CfgBufferSize, '1);
    send_item(OpSetup, '0);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    send_item(OpAlloc, '0);
    drain();

    write_reg(CfgBufferSize, '0);
    write_reg(CfgBaseAddress, '1);
    send_item(OpSetup, '0);
    send_item(OpAlloc, '0);
    drain();

    // Random part: phases of one configuration each, opened by a setup and then
    // a mix of allocates and frees whose balance differs from phase to phase.
    while (random_sent < RandomItems) begin
      drain();
      write_reg(CfgBufferSize, pick_size());
      if ($urandom_range(3) != 0) write_reg(CfgBaseAddress, pick_base());
      send_item(OpSetup, {$urandom, $urandom});
      random_sent++;
      phase_len  = $urandom_range(90, 20);
      alloc_bias = $urandom_range(80, 25);
      for (int unsigned i = 0; i < phase_len; i++) begin
        r = $urandom_range(99);
        if (r < 3)                            op = OpSetup;
        else if (r < 7)                       op = OpNop;
        else if (r < 7 + alloc_bias * 93 / 100) op = OpAlloc;
        else                                  op = OpFree;
        if (op == OpFree) send_item(op, pick_free_address());
        else              send_item(op, {$urandom, $urandom});
        random_sent++;
        // Now and then the sender holds off until every result has come back,
        // sometimes moving the base while the pool is live.
        if ($urandom_range(199) == 0) drain();
        if ($urandom_range(299) == 0) begin
          drain();
          write_reg(CfgBaseAddress, pick_base());
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/spba_pkg.sv
hdl/spba_ram.sv
hdl/slab_page_buffer_allocator.sv
verif/spba_checker.sv
verif/tb.sv
